### sv/peep_valve_close_time_learner_assert.svh
// Assertion macros for the valve close-time learner.
`ifndef PEEP_VALVE_CLOSE_TIME_LEARNER_ASSERT_SVH
`define PEEP_VALVE_CLOSE_TIME_LEARNER_ASSERT_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is low.
`define PVCT_ASSERT(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) \
		else $error("pvct assertion failed");
// Clocked check that also holds during reset.
`define PVCT_ASSERT_ALWAYS(label, clock, prop) \
	label: assert property (@(posedge clock) (prop)) \
		else $error("pvct assertion failed");
`else
`define PVCT_ASSERT(label, clock, rstn, prop)
`define PVCT_ASSERT_ALWAYS(label, clock, prop)
`endif

`endif

### sv/pvct_pkg.sv
// Shared widths, field offsets and register indexes of the valve close-time learner.
package pvct_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_TARGET_PEEP  = 3'd0;
	localparam cfg_idx_t REG_CUTOFF_PHASE = 3'd1;
	localparam cfg_idx_t REG_LAST_PHASE   = 3'd2;
	localparam cfg_idx_t REG_SETTLE_DELAY = 3'd3;
	localparam cfg_idx_t REG_START_LIMIT  = 3'd4;
	localparam int CFG_DATA_W = 16;

	// Field widths
	localparam int PEEP_W   = 6;
	localparam int PHASE_W  = 5;
	localparam int PRESS_W  = 8;
	localparam int TIME_W   = 32;
	localparam int DELAY_W  = 16;
	localparam int TARGET_W = 7;
	localparam int OUTCNT_W = 16;
	localparam int CSJ_W    = 8;

	// Input tdata layout, low bit up
	localparam int IN_PRESS_LSB  = 0;
	localparam int IN_PHASE_LSB  = IN_PRESS_LSB + PRESS_W;
	localparam int IN_NOW_LSB    = IN_PHASE_LSB + PHASE_W;
	localparam int IN_WC_LSB     = IN_NOW_LSB + TIME_W;
	localparam int IN_CLOSED_LSB = IN_WC_LSB + 1;
	localparam int IN_DATA_W     = 80;

	// Output tdata layout, low bit up
	localparam int OUT_TGT_LSB = 0;
	localparam int OUT_REL_LSB = OUT_TGT_LSB + TARGET_W;
	localparam int OUT_CHK_LSB = OUT_REL_LSB + 1;
	localparam int OUT_OL_LSB  = OUT_CHK_LSB + 1;
	localparam int OUT_NZ_LSB  = OUT_OL_LSB + OUTCNT_W;
	localparam int OUT_DATA_W  = 48;

	// Reset values of the registers
	localparam logic [PEEP_W-1:0]  PEEP_RST   = 6'd5;
	localparam logic [PHASE_W-1:0] CUTOFF_RST = 5'd8;
	localparam logic [PHASE_W-1:0] LAST_RST   = 5'd20;
	localparam logic [DELAY_W-1:0] DELAY_RST  = 16'd200;
	localparam logic [15:0]        START_RST  = 16'd10;

	// Decoded input beat
	typedef struct packed {
		logic                      new_cycle;
		logic signed [PRESS_W-1:0] pressure;
		logic [PHASE_W-1:0]        phase;
		logic [TIME_W-1:0]         now_ms;
		logic                      valve_was_closed;
		logic [TIME_W-1:0]         closed_at_ms;
	} in_item_t;

endpackage

### sv/peep_valve_close_time_learner.sv
// Exhalation valve close-time learner: open/close target per tick and open-limit learning.
//
// Usage:
//  - s_tvalid/s_tready/s_tdata/s_tuser take one pressure sample per control tick.
//    s_tuser carries new_cycle, which clears the per-breath counters before the tick.
//  - m_tvalid/m_tready/m_tdata return one result beat per input beat, in order.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write the five registers; cfg_ready is
//    always high. Write only while no beat is in flight. Writing start_limit also
//    loads the open-limit at once.
// Path: an accepted input beat goes into the input register, then its result into
// the result register and onto m_tdata.
// Throughput: one beat per cycle while m_tready is high. The state (open-limit,
// tick counters, check flag) is read and rewritten as a beat moves from the input
// register into the result register, so the next beat sees it right away.
// Reset: arst_n low clears the valid flags of both pipeline registers, the counters
// and the check flag, loads register reset values and sets the open-limit to start_limit.
// Stall: while m_tready is low the result register holds its beat; the input
// register still takes one more beat, then s_tready drops until the result moves.
module peep_valve_close_time_learner #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// pressure[7:0], phase[12:8], now_ms[44:13], valve_was_closed[45],
	// closed_at_ms[77:46], zero pad[79:78]
	input  logic [pvct_pkg::IN_DATA_W-1:0]      s_tdata,
	// new_cycle[0]
	input  logic                                s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// valve_target[6:0], release_now[7], checked[8], open_limit_now[24:9],
	// near_zero_ticks[40:25], zero pad[47:41]
	output logic [pvct_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pvct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pvct_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pvct_pkg::*;

	`include "peep_valve_close_time_learner_assert.svh"

	localparam int CW = COUNT_BITS;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
	// Divide by three of a (CW+1)-bit value by reciprocal multiply
	localparam int DIV_W = CW + 1;
	localparam logic [DIV_W:0] DIV3_MUL =
		(DIV_W+1)'(((longint'(1) << (DIV_W + 1)) + 2) / 3);

	// Configuration registers
	logic [PEEP_W-1:0]  peep_q;
	logic [PHASE_W-1:0] cutoff_q;
	logic [PHASE_W-1:0] last_q;
	logic [DELAY_W-1:0] delay_q;

	// Learner state
	logic [CW-1:0]    open_limit_q;
	logic [CW-1:0]    tick_q;
	logic [CW-1:0]    low_tick_q;
	logic [CSJ_W-1:0] csj_q;
	logic             checked_q;

	// Pipeline
	logic     v_s1;
	in_item_t item_s1;
	logic     v_s2;
	logic [OUT_DATA_W-1:0] data_s2;

	logic adv;
	logic cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// Handshake: the result register frees up when taken, input follows
	assign adv      = v_s1 & (~v_s2 | m_tready);
	assign s_tready = ~v_s1 | adv;
	assign m_tvalid = v_s2;
	assign m_tdata  = data_s2;

	// Start limit saturated to the counter width
	logic [CW+15:0] start_ext;
	logic [CW-1:0]  start_sat;
	assign start_ext = {{CW{1'b0}}, cfg_data};
	assign start_sat = (|start_ext[CW+15:CW]) ? CNT_MAX : start_ext[CW-1:0];

	logic [CW+15:0] start_rst_ext;
	logic [CW-1:0]  start_rst_sat;
	assign start_rst_ext = {{CW{1'b0}}, START_RST};
	assign start_rst_sat = (|start_rst_ext[CW+15:CW]) ? CNT_MAX : start_rst_ext[CW-1:0];

	// ---------------- per-tick datapath ----------------
	logic signed [8:0] p9;
	logic signed [8:0] peep9;
	logic signed [8:0] half9;
	logic signed [8:0] peep32_9;
	logic signed [8:0] peep4_9;
	logic [CW-1:0]     tc;
	logic [CW-1:0]     lt;
	logic              cf;
	logic              below_limit;
	logic              is_last;
	logic              p_low;
	logic [CW-1:0]     lt_next;
	logic [CW-1:0]     tick_next;
	logic [6:0]        open_tgt;
	logic [6:0]        close_tgt;
	logic [TARGET_W-1:0] target;
	logic [TIME_W-1:0] ready_at;
	logic              settled;
	logic              do_chk;
	logic [CSJ_W-1:0]  csj_inc;
	logic              jump_down;
	logic              jump_up;
	logic              step_down;
	logic              step_up;
	logic              release_now;
	logic [CSJ_W-1:0]  csj_next;
	logic [DIV_W-1:0]  dbl;
	logic [2*DIV_W:0]  prod;
	logic [CW-1:0]     two_thirds;
	logic [CW:0]       three_half;
	logic [CW-1:0]     three_half_sat;
	logic [CW-1:0]     lim_a;
	logic [CW-1:0]     lim_b;
	logic [CW-1:0]     ol_next;
	logic              cf_next;
	logic [CW+15:0]    ol_out_ext;
	logic [CW+15:0]    lt_out_ext;

	always_comb begin
		p9       = 9'(item_s1.pressure);
		peep9    = $signed({3'b000, peep_q});
		half9    = $signed({4'b0000, peep_q[PEEP_W-1:1]});
		peep32_9 = $signed({3'b000, peep_q}) + $signed({4'b0000, peep_q[PEEP_W-1:1]});
		peep4_9  = peep9 + 9'sd4;

		// Per-breath counters cleared by new_cycle first
		tc = item_s1.new_cycle ? '0 : tick_q;
		lt = item_s1.new_cycle ? '0 : low_tick_q;
		cf = item_s1.new_cycle ? 1'b0 : checked_q;

		below_limit = tc < open_limit_q;
		is_last     = item_s1.phase == last_q;
		p_low       = p9 < half9;

		lt_next = (below_limit && p_low && lt != CNT_MAX) ? lt + 1'b1 : lt;
		tick_next = (tc != CNT_MAX) ? tc + 1'b1 : tc;

		// Valve target: open saturates at the top of the field
		open_tgt  = ({1'b0, peep_q} > 7'd58) ? 7'd63 : {1'b0, peep_q} + 7'd5;
		close_tgt = {1'b0, peep_q} - 7'd5;
		target    = (!below_limit || is_last) ? close_tgt : open_tgt;

		// Once-per-breath check after settling or in the last phase
		ready_at = item_s1.closed_at_ms + {{(TIME_W-DELAY_W){1'b0}}, delay_q};
		settled  = item_s1.valve_was_closed && (item_s1.phase > cutoff_q)
			&& (item_s1.now_ms > ready_at);
		do_chk   = (settled || is_last) && !cf;

		csj_inc   = (csj_q != 8'd255) ? csj_q + 1'b1 : csj_q;
		jump_down = do_chk && p_low && (csj_inc > 8'd8);
		jump_up   = do_chk && (p9 > peep32_9);
		step_down = do_chk && (p9 < peep9);
		step_up   = do_chk && (p9 > peep9);
		release_now = do_chk && (p9 > peep4_9);

		if (!do_chk) begin
			csj_next = csj_q;
		end else if (jump_down || jump_up) begin
			csj_next = '0;
		end else begin
			csj_next = csj_inc;
		end

		// Ratio jump, the two directions exclude each other
		dbl        = {open_limit_q, 1'b0};
		prod       = (2*DIV_W+1)'(dbl) * (2*DIV_W+1)'(DIV3_MUL);
		two_thirds = prod[CW+DIV_W:DIV_W+1];
		three_half = {1'b0, open_limit_q} + {2'b00, open_limit_q[CW-1:1]};
		three_half_sat = three_half[CW] ? CNT_MAX : three_half[CW-1:0];

		priority if (jump_down) begin
			lim_a = two_thirds;
		end else if (jump_up) begin
			lim_a = three_half_sat;
		end else begin
			lim_a = open_limit_q;
		end

		// Single step, floor of one and saturation at the top
		priority if (step_down) begin
			lim_b = (lim_a <= CW'(1)) ? CW'(1) : lim_a - 1'b1;
		end else if (step_up) begin
			lim_b = (lim_a != CNT_MAX) ? lim_a + 1'b1 : lim_a;
		end else begin
			lim_b = lim_a;
		end
		ol_next = lim_b;
		cf_next = do_chk | cf;

		ol_out_ext = {16'h0000, ol_next};
		lt_out_ext = {16'h0000, lt_next};
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peep_q   <= PEEP_RST;
			cutoff_q <= CUTOFF_RST;
			last_q   <= LAST_RST;
			delay_q  <= DELAY_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TARGET_PEEP:  peep_q   <= cfg_data[PEEP_W-1:0];
				REG_CUTOFF_PHASE: cutoff_q <= cfg_data[PHASE_W-1:0];
				REG_LAST_PHASE:   last_q   <= cfg_data[PHASE_W-1:0];
				REG_SETTLE_DELAY: delay_q  <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Learner state, updated as a beat moves into the result register; a start_limit write also loads the open-limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_limit_q <= start_rst_sat;
			tick_q       <= '0;
			low_tick_q   <= '0;
			csj_q        <= '0;
			checked_q    <= 1'b0;
		end else begin
			if (cfg_wr && cfg_index == REG_START_LIMIT) begin
				open_limit_q <= start_sat;
			end else if (adv) begin
				open_limit_q <= ol_next;
			end
			if (adv) begin
				tick_q     <= tick_next;
				low_tick_q <= lt_next;
				csj_q      <= csj_next;
				checked_q  <= cf_next;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.new_cycle        <= s_tuser;
			item_s1.pressure         <= s_tdata[IN_PRESS_LSB +: PRESS_W];
			item_s1.phase            <= s_tdata[IN_PHASE_LSB +: PHASE_W];
			item_s1.now_ms           <= s_tdata[IN_NOW_LSB +: TIME_W];
			item_s1.valve_was_closed <= s_tdata[IN_WC_LSB];
			item_s1.closed_at_ms     <= s_tdata[IN_CLOSED_LSB +: TIME_W];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (~v_s2 | m_tready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {7'b0000000,
				lt_out_ext[OUTCNT_W-1:0],
				ol_out_ext[OUTCNT_W-1:0],
				do_chk,
				release_now,
				target};
		end
	end

	// ---------------- assertions ----------------
	`PVCT_ASSERT(a_one_check_per_breath, clk, arst_n,
		(adv && checked_q && !item_s1.new_cycle) |=> !data_s2[OUT_CHK_LSB])
	`PVCT_ASSERT(a_release_needs_check, clk, arst_n,
		v_s2 |-> (!data_s2[OUT_REL_LSB] || data_s2[OUT_CHK_LSB]))
	`PVCT_ASSERT(a_tick_counts_up, clk, arst_n,
		(adv && !item_s1.new_cycle && tick_q != CNT_MAX) |=> (tick_q == $past(tick_q) + 1'b1))
	`PVCT_ASSERT(a_low_within_ticks, clk, arst_n,
		low_tick_q <= tick_q)

endmodule
